>>> hdl/rpq_pkg.sv
package rpq_pkg;

    localparam int unsigned NumAnsi   = 16;
    localparam int unsigned NumGroups = 4;
    localparam int unsigned GroupSize = NumAnsi / NumGroups;

    localparam logic [1:0] ACT_TO256 = 2'd0;
    localparam logic [1:0] ACT_TO16  = 2'd1;
    localparam logic [1:0] ACT_IDX16 = 2'd2;

    localparam logic [7:0] CubeBase   = 8'd16;
    localparam logic [7:0] GrayBase   = 8'd232;
    localparam logic [7:0] GrayOffset = 8'd8;
    localparam logic [4:0] MaxStep    = 5'd23;

    typedef logic [7:0]  t_chan;
    typedef logic [15:0] t_sq;
    typedef logic [19:0] t_dist;
    typedef logic [1:0]  t_acode;

    // Stage 1 payload: working color, cube targets and gray step
    typedef struct packed {
        logic [1:0] action;
        logic       pass;
        t_chan      idx;
        t_chan      red;
        t_chan      green;
        t_chan      blue;
        t_chan      cube_r;
        t_chan      cube_g;
        t_chan      cube_b;
        logic [2:0] lvl_r;
        logic [2:0] lvl_g;
        logic [2:0] lvl_b;
        logic [4:0] step;
        t_chan      gray;
    } t_front;

    // Stage 3 payload: all candidate distances
    typedef struct packed {
        logic [1:0]              action;
        logic                    pass;
        t_chan                   idx;
        t_chan                   cube_entry;
        logic [4:0]              step;
        t_dist                   cube_d;
        t_dist                   gray_d;
        t_dist [NumAnsi-1:0]     ansi_d;
    } t_dist_item;

    function automatic t_chan level_value(logic [2:0] li);
        t_chan v;
        case (li)
            3'd0:    v = 8'd0;
            3'd1:    v = 8'd95;
            3'd2:    v = 8'd135;
            3'd3:    v = 8'd175;
            3'd4:    v = 8'd215;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

    // Equivalent to the threshold rule with (v - 35) / 40 above 115
    function automatic logic [2:0] level_index(t_chan v);
        logic [2:0] li;
        if (v < 8'd48)       li = 3'd0;
        else if (v < 8'd115) li = 3'd1;
        else if (v < 8'd155) li = 3'd2;
        else if (v < 8'd195) li = 3'd3;
        else if (v < 8'd235) li = 3'd4;
        else                 li = 3'd5;
        return li;
    endfunction

    // ANSI components take only four values
    function automatic t_chan acode_value(t_acode c);
        t_chan v;
        case (c)
            2'd0:    v = 8'h00;
            2'd1:    v = 8'h80;
            2'd2:    v = 8'hc0;
            default: v = 8'hff;
        endcase
        return v;
    endfunction

    // {red, green, blue} component codes of each ANSI color
    function automatic logic [5:0] ansi_codes(logic [3:0] i);
        logic [5:0] c;
        case (i)
            4'd0:    c = {2'd0, 2'd0, 2'd0};
            4'd1:    c = {2'd1, 2'd0, 2'd0};
            4'd2:    c = {2'd0, 2'd1, 2'd0};
            4'd3:    c = {2'd1, 2'd1, 2'd0};
            4'd4:    c = {2'd0, 2'd0, 2'd1};
            4'd5:    c = {2'd1, 2'd0, 2'd1};
            4'd6:    c = {2'd0, 2'd1, 2'd1};
            4'd7:    c = {2'd2, 2'd2, 2'd2};
            4'd8:    c = {2'd1, 2'd1, 2'd1};
            4'd9:    c = {2'd3, 2'd0, 2'd0};
            4'd10:   c = {2'd0, 2'd3, 2'd0};
            4'd11:   c = {2'd3, 2'd3, 2'd0};
            4'd12:   c = {2'd0, 2'd0, 2'd3};
            4'd13:   c = {2'd3, 2'd0, 2'd3};
            4'd14:   c = {2'd0, 2'd3, 2'd3};
            default: c = {2'd3, 2'd3, 2'd3};
        endcase
        return c;
    endfunction

    function automatic t_sq sq_diff(t_chan a, t_chan b);
        t_chan d;
        d = (a > b) ? (a - b) : (b - a);
        return t_sq'(d) * t_sq'(d);
    endfunction

    // 2*r + 4*g + 3*b
    function automatic t_dist wsum(t_sq r, t_sq g, t_sq b);
        return {3'b0, r, 1'b0} + {2'b0, g, 2'b0} + {4'b0, b} + {3'b0, b, 1'b0};
    endfunction

endpackage

>>> hdl/rpq_if.sv
interface rpq_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] palette_index;

    modport source (output valid, action, red, green, blue, palette_index, input ready);
    modport sink   (input valid, action, red, green, blue, palette_index, output ready);
endinterface

interface rpq_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] color_index;

    modport source (output valid, color_index, input ready);
    modport sink   (input valid, color_index, output ready);
endinterface

>>> hdl/rpq_front.sv
module rpq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rpq_in_if.sink            i_in,
    output logic              o_valid,
    input  logic              i_ready,
    output rpq_pkg::t_front   o_data
);

    logic            r_valid;
    rpq_pkg::t_front r_data;
    rpq_pkg::t_front n_data;
    logic            adv;

    logic [9:0]      sum;
    logic [4:0]      step;
    logic [7:0]      v;
    logic [7:0]      rem;
    logic [2:0]      q36;
    logic [2:0]      q6;
    logic [2:0]      bl;
    logic [4:0]      gidx;
    rpq_pkg::t_chan  gray_x;
    rpq_pkg::t_chan  er;
    rpq_pkg::t_chan  eg;
    rpq_pkg::t_chan  eb;
    logic            is_idx;

    assign adv        = !r_valid || i_ready;
    assign i_in.ready = adv;
    assign o_valid    = r_valid;
    assign o_data     = r_data;

    always_comb begin
        sum = 10'(i_in.red) + 10'(i_in.green) + 10'(i_in.blue);
        // gray step = (sum - 9) / 30, capped
        step = 5'd0;
        for (int k = 1; k <= 23; k++) begin
            if (sum >= 10'(9 + 30 * k)) begin
                step = 5'(k);
            end
        end

        // expand a cube index into its three level codes
        v   = i_in.palette_index - rpq_pkg::CubeBase;
        q36 = 3'd0;
        for (int k = 1; k <= 5; k++) begin
            if (v >= 8'(36 * k)) begin
                q36 = 3'(k);
            end
        end
        rem = v - {5'd0, q36} * 8'd36;
        q6  = 3'd0;
        for (int k = 1; k <= 5; k++) begin
            if (rem >= 8'(6 * k)) begin
                q6 = 3'(k);
            end
        end
        bl = 3'(rem - {5'd0, q6} * 8'd6);

        gidx   = 5'(i_in.palette_index - rpq_pkg::GrayBase);
        gray_x = rpq_pkg::GrayOffset + {3'd0, gidx} * 8'd10;
        if (i_in.palette_index >= rpq_pkg::GrayBase) begin
            er = gray_x;
            eg = gray_x;
            eb = gray_x;
        end else begin
            er = rpq_pkg::level_value(q36);
            eg = rpq_pkg::level_value(q6);
            eb = rpq_pkg::level_value(bl);
        end

        is_idx = (i_in.action == rpq_pkg::ACT_IDX16);

        n_data.action = i_in.action;
        n_data.pass   = (i_in.palette_index < rpq_pkg::CubeBase);
        n_data.idx    = i_in.palette_index;
        n_data.red    = is_idx ? er : i_in.red;
        n_data.green  = is_idx ? eg : i_in.green;
        n_data.blue   = is_idx ? eb : i_in.blue;
        n_data.lvl_r  = rpq_pkg::level_index(i_in.red);
        n_data.lvl_g  = rpq_pkg::level_index(i_in.green);
        n_data.lvl_b  = rpq_pkg::level_index(i_in.blue);
        n_data.cube_r = rpq_pkg::level_value(n_data.lvl_r);
        n_data.cube_g = rpq_pkg::level_value(n_data.lvl_g);
        n_data.cube_b = rpq_pkg::level_value(n_data.lvl_b);
        n_data.step   = step;
        n_data.gray   = rpq_pkg::GrayOffset + {3'd0, step} * 8'd10;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_data <= n_data;
        end
    end

    a_step_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_data.step <= rpq_pkg::MaxStep))
        else $error("gray step beyond ramp");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_data)))
        else $error("stage 1 item changed while stalled");

endmodule

>>> hdl/rpq_dist.sv
module rpq_dist (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  rpq_pkg::t_front      i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rpq_pkg::t_dist_item  o_data
);

    // stage 2: squared differences, shared by all ANSI lanes
    logic                r_v2;
    rpq_pkg::t_sq        r_sq_r [4];
    rpq_pkg::t_sq        r_sq_g [4];
    rpq_pkg::t_sq        r_sq_b [4];
    rpq_pkg::t_sq        r_cube_sq [3];
    rpq_pkg::t_sq        r_gray_sq [3];
    logic [1:0]          r_action2;
    logic                r_pass2;
    rpq_pkg::t_chan      r_idx2;
    rpq_pkg::t_chan      r_cube_entry2;
    logic [4:0]          r_step2;
    rpq_pkg::t_chan      n_cube_entry;

    // stage 3: weighted distances
    logic                r_v3;
    rpq_pkg::t_dist_item r_data3;
    rpq_pkg::t_dist_item n_data3;

    logic                adv2;
    logic                adv3;
    logic [5:0]          codes;

    assign adv3    = !r_v3 || i_ready;
    assign adv2    = !r_v2 || adv3;
    assign o_ready = adv2;
    assign o_valid = r_v3;
    assign o_data  = r_data3;

    assign n_cube_entry = rpq_pkg::CubeBase + {5'd0, i_data.lvl_r} * 8'd36
                        + {5'd0, i_data.lvl_g} * 8'd6 + {5'd0, i_data.lvl_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv2) begin
                r_v2 <= i_valid;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            for (int j = 0; j < 4; j++) begin
                r_sq_r[j] <= rpq_pkg::sq_diff(i_data.red, rpq_pkg::acode_value(2'(j)));
                r_sq_g[j] <= rpq_pkg::sq_diff(i_data.green, rpq_pkg::acode_value(2'(j)));
                r_sq_b[j] <= rpq_pkg::sq_diff(i_data.blue, rpq_pkg::acode_value(2'(j)));
            end
            r_cube_sq[0]  <= rpq_pkg::sq_diff(i_data.red, i_data.cube_r);
            r_cube_sq[1]  <= rpq_pkg::sq_diff(i_data.green, i_data.cube_g);
            r_cube_sq[2]  <= rpq_pkg::sq_diff(i_data.blue, i_data.cube_b);
            r_gray_sq[0]  <= rpq_pkg::sq_diff(i_data.red, i_data.gray);
            r_gray_sq[1]  <= rpq_pkg::sq_diff(i_data.green, i_data.gray);
            r_gray_sq[2]  <= rpq_pkg::sq_diff(i_data.blue, i_data.gray);
            r_action2     <= i_data.action;
            r_pass2       <= i_data.pass;
            r_idx2        <= i_data.idx;
            r_cube_entry2 <= n_cube_entry;
            r_step2       <= i_data.step;
        end
    end

    always_comb begin
        codes              = 6'd0;
        n_data3.action     = r_action2;
        n_data3.pass       = r_pass2;
        n_data3.idx        = r_idx2;
        n_data3.cube_entry = r_cube_entry2;
        n_data3.step       = r_step2;
        n_data3.cube_d     = rpq_pkg::wsum(r_cube_sq[0], r_cube_sq[1], r_cube_sq[2]);
        n_data3.gray_d     = rpq_pkg::wsum(r_gray_sq[0], r_gray_sq[1], r_gray_sq[2]);
        for (int i = 0; i < rpq_pkg::NumAnsi; i++) begin
            codes = rpq_pkg::ansi_codes(4'(i));
            n_data3.ansi_d[i] = rpq_pkg::wsum(r_sq_r[codes[5:4]], r_sq_g[codes[3:2]],
                                              r_sq_b[codes[1:0]]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_data3 <= n_data3;
        end
    end

endmodule

>>> hdl/rpq_select.sv
module rpq_select (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  rpq_pkg::t_dist_item  i_data,
    rpq_out_if.source            o_out
);

    localparam int unsigned NumGroups = rpq_pkg::NumGroups;
    localparam int unsigned GroupSize = rpq_pkg::GroupSize;

    // stage 4: best of each group of four, cube versus gray
    logic                r_v4;
    rpq_pkg::t_dist      r_gd [NumGroups];
    logic [3:0]          r_gi [NumGroups];
    rpq_pkg::t_chan      r_pal256;
    logic [1:0]          r_action4;
    logic                r_pass4;
    rpq_pkg::t_chan      r_idx4;
    rpq_pkg::t_dist      n_gd [NumGroups];
    logic [3:0]          n_gi [NumGroups];
    rpq_pkg::t_chan      n_pal256;

    // stage 5: output register
    logic                r_ovalid;
    rpq_pkg::t_chan      r_color;
    rpq_pkg::t_chan      n_color;
    rpq_pkg::t_dist      d_lo;
    rpq_pkg::t_dist      d_hi;
    logic [3:0]          i_lo;
    logic [3:0]          i_hi;
    logic [3:0]          best;

    logic                adv4;
    logic                adv5;

    assign adv5              = !r_ovalid || o_out.ready;
    assign adv4              = !r_v4 || adv5;
    assign o_ready           = adv4;
    assign o_out.valid       = r_ovalid;
    assign o_out.color_index = r_color;

    // the later candidate wins only when strictly nearer, so low indices win ties
    always_comb begin
        for (int g = 0; g < NumGroups; g++) begin
            n_gd[g] = i_data.ansi_d[g * GroupSize];
            n_gi[g] = 4'(g * GroupSize);
            for (int k = 1; k < GroupSize; k++) begin
                if (i_data.ansi_d[g * GroupSize + k] < n_gd[g]) begin
                    n_gd[g] = i_data.ansi_d[g * GroupSize + k];
                    n_gi[g] = 4'(g * GroupSize + k);
                end
            end
        end
        if (i_data.gray_d < i_data.cube_d) begin
            n_pal256 = rpq_pkg::GrayBase + {3'd0, i_data.step};
        end else begin
            n_pal256 = i_data.cube_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r_gd      <= n_gd;
            r_gi      <= n_gi;
            r_pal256  <= n_pal256;
            r_action4 <= i_data.action;
            r_pass4   <= i_data.pass;
            r_idx4    <= i_data.idx;
        end
    end

    always_comb begin
        d_lo = r_gd[0];
        i_lo = r_gi[0];
        if (r_gd[1] < d_lo) begin
            d_lo = r_gd[1];
            i_lo = r_gi[1];
        end
        d_hi = r_gd[2];
        i_hi = r_gi[2];
        if (r_gd[3] < d_hi) begin
            d_hi = r_gd[3];
            i_hi = r_gi[3];
        end
        best = (d_hi < d_lo) ? i_hi : i_lo;

        case (r_action4)
            rpq_pkg::ACT_TO256: n_color = r_pal256;
            rpq_pkg::ACT_TO16:  n_color = {4'd0, best};
            rpq_pkg::ACT_IDX16: n_color = r_pass4 ? r_idx4 : {4'd0, best};
            default:            n_color = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (adv4) begin
                r_v4 <= i_valid;
            end
            if (adv5) begin
                r_ovalid <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv5) begin
            r_color <= n_color;
        end
    end

    a_pal256_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (r_pal256 >= rpq_pkg::CubeBase))
        else $error("256-palette answer falls in the ANSI range");

    a_stage4_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !adv5) |=> (r_v4 && $stable(r_pal256) && $stable(r_action4)))
        else $error("stage 4 item changed while stalled");

    a_ansi_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && adv5 && (r_action4 == rpq_pkg::ACT_TO16 ||
                          r_action4 == rpq_pkg::ACT_IDX16))
        |=> (r_color[7:4] == 4'd0))
        else $error("16-color answer out of range");

endmodule

>>> hdl/rgb_palette_quantizer_core.sv
// Maps one color item per clock onto terminal palettes: RGB to the xterm 256
// palette (nearest 6x6x6 cube entry against nearest gray-ramp step, gray only
// when strictly nearer), RGB to the 16 ANSI colors (lowest index on a tie),
// or a 256-palette index to the 16 ANSI colors (indices below 16 pass
// through). Every distance is 2*dr^2 + 4*dg^2 + 3*db^2. The block takes one
// item every cycle while the output is not stalled; the five register stages
// are index expansion and level choice (loaded at the accepting edge), squared
// differences, weighted sums, and two levels of the nearest-color compare tree,
// the last of which is the output register. Back-pressure on the output stalls
// only the stages that are full, so up to five items are held.
module rgb_palette_quantizer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rpq_in_if.sink     i_in,
    rpq_out_if.source  o_out
);

    logic                front_valid;
    logic                front_ready;
    rpq_pkg::t_front     front_data;
    logic                dist_valid;
    logic                dist_ready;
    rpq_pkg::t_dist_item dist_data;

    rpq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (front_valid),
        .i_ready (front_ready),
        .o_data  (front_data)
    );

    rpq_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_data  (front_data),
        .o_valid (dist_valid),
        .i_ready (dist_ready),
        .o_data  (dist_data)
    );

    rpq_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dist_valid),
        .o_ready (dist_ready),
        .i_data  (dist_data),
        .o_out   (o_out)
    );

endmodule
